@@ hw/rtl/clipped_shape_fill_engine_top_defines.svh @@
// Assertion macros used by the clipped shape fill engine top module.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef CLIPPED_SHAPE_FILL_ENGINE_TOP_DEFINES_SVH
`define CLIPPED_SHAPE_FILL_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cfe_pkg.sv @@
// Shared types, constants and the FNV-1a step for the clipped shape fill engine.
// No dependencies; imported by every module of the block except cfe_frame_mem.
package cfe_pkg;

    // Signed coordinate width: holds pos +/- 255 and the frame bounds
    localparam int CW = 12;

    // Square root unit widths
    localparam int RAD_W  = 16;
    localparam int ROOT_W = 8;

    // Stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 136;

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    typedef enum logic [1:0] {
        CMD_RECT = 2'd0,
        CMD_DISC = 2'd1,
        CMD_HASH = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECT,
        ST_RECT_DRAIN,
        ST_DISC_ROW,
        ST_DISC_SQRT,
        ST_DISC_RD,
        ST_DISC_WR,
        ST_HASH_RD,
        ST_HASH_LOAD,
        ST_HASH_RUN,
        ST_RD_RD,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic init;
        logic load;
    } hash_ctrl_t;

    // One FNV-1a step on a pixel byte of 0 or 1. The prime 2^40 + 0x1b3
    // is applied as shifts and adds: 0x1b3 = 256 + 128 + 32 + 16 + 2 + 1.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic px);
        logic [63:0] x;
        x = h ^ {63'd0, px};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ hw/rtl/cfe_frame_mem.sv @@
// Framebuffer store: one row of pixels per entry, one write and one read port.
// Read data is registered. Uses nothing from the package.
module cfe_frame_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 128,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/cfe_isqrt.sv @@
// Iterative integer square root, one root bit per cycle.
// Depends on cfe_pkg for RAD_W and ROOT_W.
module cfe_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cfe_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [cfe_pkg::ROOT_W-1:0] root
);
    import cfe_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] res_reg, res_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = REM_W'({res_reg[ROOT_W-2:0], 2'b01});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            res_next  = '0;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                res_next = {res_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                res_next = {res_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

@@ hw/rtl/cfe_fnv_hash.sv @@
// FNV-1a 64 hasher: walks a loaded framebuffer row one pixel per cycle.
// Depends on cfe_pkg for FNV_BASIS, fnv_step and hash_ctrl_t.
module cfe_fnv_hash #(
    parameter int WIDTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfe_pkg::hash_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    row_data,
    output logic                busy,
    output logic [63:0]         hash
);
    import cfe_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic [63:0]      hash_reg, hash_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] shift_reg, shift_next;

    // Restart, load a row, or fold in the next pixel
    always_comb
    begin
        hash_next  = hash_reg;
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        if (ctrl.init)
        begin
            hash_next = FNV_BASIS;
        end
        if (ctrl.load)
        begin
            shift_next = row_data;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            hash_next  = fnv_step(hash_reg, shift_reg[0]);
            shift_next = shift_reg >> 1;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign busy = busy_reg;
    assign hash = hash_reg;

endmodule

@@ hw/rtl/clipped_shape_fill_engine_top.sv @@
// Clipped shape fill engine: command decode, row sequencer and result stage.
// Depends on cfe_pkg, cfe_frame_mem, cfe_isqrt, cfe_fnv_hash and the defines header.
//
// Usage: one command item enters on s_* (kind on s_tuser), one result item
// leaves on m_* for every command. Commands run one at a time in order.
// Work per command after acceptance (H = FRAME_HEIGHT):
//   fill rectangle  one row read-modify-written per cycle, reads and
//                   writes overlapped on the two frame store ports
//   fill disc       per row the squared half-span r^2 - dy^2, an 8-step square
//                   root of it, then a row read and a row write
//   hash frame      each row read and loaded, then its pixels folded one per cycle
//   read segment    one row read, none when the row lies outside the frame
// Throughput: the next command is taken the cycle after the previous one
// reaches the result register.
// Reset: the frame store is swept to zero, one row per cycle, H cycles after
// reset release; s_tready stays low until the sweep ends.
// Stall: a finished result waits in the output register. A new command is
// still taken, but its result is held back until the waiting one is taken.
`include "clipped_shape_fill_engine_top_defines.svh"

module clipped_shape_fill_engine_top #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[9:0], pos_y[19:10], rect_width[27:20], rect_height[35:28],
    // radius[43:36], segment[44], zero pad [47:45]
    input  logic [cfe_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // frame_hash[63:0], row_pixels[127:64], done_res[128], zero pad [135:129]
    output logic [cfe_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import cfe_pkg::*;

    localparam int ROW_AW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int ROW_WORDS = (FRAME_WIDTH + 63) / 64;
    localparam int PADW      = ((ROW_WORDS > 2) ? ROW_WORDS : 2) * 64;

    localparam logic signed [CW-1:0] H_S   = CW'(FRAME_HEIGHT);
    localparam logic signed [CW-1:0] ONE_S = CW'(1);

    // Control and datapath registers
    state_t                  state_reg, state_next;
    logic signed [CW-1:0]    yy_reg, yy_next;
    logic signed [CW-1:0]    yend_reg, yend_next;
    logic                    wr_pending_reg, wr_pending_next;
    logic [ROW_AW-1:0]       wr_row_reg, wr_row_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    cmd_t                    cmd_reg, cmd_next;
    logic signed [CW-1:0]    px_reg, px_next;
    logic signed [CW-1:0]    py_reg, py_next;
    logic [7:0]              w_reg, w_next;
    logic [7:0]              r_reg, r_next;
    logic                    seg_reg, seg_next;
    logic [63:0]             row_buf_reg, row_buf_next;
    logic [63:0]             frame_hash_reg, frame_hash_next;
    logic [63:0]             row_pixels_reg, row_pixels_next;

    // Decoded input item
    logic                    accept;
    cmd_t                    in_cmd;
    logic signed [CW-1:0]    in_px, in_py, in_h, in_r;
    logic signed [CW-1:0]    rect_y0, rect_yend, disc_y0, disc_y1;
    logic                    read_in_frame;

    // Frame store ports
    logic                    wr_en, rd_en;
    logic [ROW_AW-1:0]       wr_addr, rd_addr;
    logic [FRAME_WIDTH-1:0]  wr_data, rd_data;
    logic [FRAME_WIDTH-1:0]  fill_mask;
    logic [PADW-1:0]         row_pad;

    // Disc span
    logic signed [CW-1:0]    dy, ady;
    logic [RAD_W-1:0]        span_sq;
    logic                    sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]       root;
    logic signed [CW-1:0]    root_s;
    logic signed [CW-1:0]    rect_lo, rect_hi, disc_lo, disc_hi;

    // Hash and result
    hash_ctrl_t              hash_ctrl;
    logic                    hash_busy;
    logic [63:0]             hash_val;
    logic                    out_load;

    // Field decode
    always_comb
    begin
        in_cmd = cmd_t'(s_tuser);
        in_px  = CW'($signed(s_tdata[9:0]));
        in_py  = CW'($signed(s_tdata[19:10]));
        in_h   = $signed({{(CW-8){1'b0}}, s_tdata[35:28]});
        in_r   = $signed({{(CW-8){1'b0}}, s_tdata[43:36]});
    end

    // Clip the row ranges at acceptance
    always_comb
    begin
        rect_y0       = (in_py < 0) ? '0 : in_py;
        rect_yend     = (in_py + in_h > H_S) ? H_S : in_py + in_h;
        disc_y0       = (in_py - in_r < 0) ? '0 : in_py - in_r;
        disc_y1       = (in_py + in_r >= H_S) ? H_S - ONE_S : in_py + in_r;
        read_in_frame = (in_py >= 0) && (in_py < H_S);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (yy_reg == H_S - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_cmd)
                        CMD_RECT: state_next = (rect_y0 < rect_yend) ? ST_RECT : ST_FINISH;
                        CMD_DISC: state_next = (disc_y0 <= disc_y1) ? ST_DISC_ROW : ST_FINISH;
                        CMD_HASH: state_next = ST_HASH_RD;
                        CMD_READ: state_next = read_in_frame ? ST_RD_RD : ST_FINISH;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RECT:
            begin
                if (yy_reg + 1 >= yend_reg)
                begin
                    state_next = ST_RECT_DRAIN;
                end
            end
            ST_RECT_DRAIN: state_next = ST_FINISH;
            ST_DISC_ROW:   state_next = ST_DISC_SQRT;
            ST_DISC_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_DISC_RD;
                end
            end
            ST_DISC_RD:    state_next = ST_DISC_WR;
            ST_DISC_WR:    state_next = (yy_reg + 1 >= yend_reg) ? ST_FINISH : ST_DISC_ROW;
            ST_HASH_RD:    state_next = ST_HASH_LOAD;
            ST_HASH_LOAD:  state_next = ST_HASH_RUN;
            ST_HASH_RUN:
            begin
                if (!hash_busy)
                begin
                    state_next = (yy_reg + 1 >= yend_reg) ? ST_FINISH : ST_HASH_RD;
                end
            end
            ST_RD_RD:      state_next = ST_RD_WAIT;
            ST_RD_WAIT:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        accept         = s_tvalid && s_tready;
        rd_en          = (state_reg == ST_RECT) || (state_reg == ST_DISC_RD) ||
                         (state_reg == ST_HASH_RD) || (state_reg == ST_RD_RD);
        rd_addr        = yy_reg[ROW_AW-1:0];
        wr_en          = (state_reg == ST_CLEAR) || wr_pending_reg;
        wr_addr        = (state_reg == ST_CLEAR) ? yy_reg[ROW_AW-1:0] : wr_row_reg;
        wr_data        = (state_reg == ST_CLEAR) ? '0 : (rd_data | fill_mask);
        sqrt_start     = (state_reg == ST_DISC_ROW);
        hash_ctrl.init = accept && (in_cmd == CMD_HASH);
        hash_ctrl.load = (state_reg == ST_HASH_LOAD);
        out_load       = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    end

    // Squared half-span of the current disc row: r^2 - dy^2, never negative
    always_comb
    begin
        dy      = yy_reg - py_reg;
        ady     = dy[CW-1] ? -dy : dy;
        span_sq = RAD_W'(r_reg) * RAD_W'(r_reg) - RAD_W'(ady[7:0]) * RAD_W'(ady[7:0]);
    end

    // Column mask of the row being filled
    always_comb
    begin
        root_s  = $signed({{(CW-ROOT_W){1'b0}}, root});
        rect_lo = px_reg;
        rect_hi = px_reg + $signed({{(CW-8){1'b0}}, w_reg});
        disc_lo = px_reg - root_s;
        disc_hi = px_reg + root_s;
        for (int c = 0; c < FRAME_WIDTH; c++)
        begin
            if (cmd_reg == CMD_RECT)
            begin
                fill_mask[c] = ($signed(CW'(c)) >= rect_lo) && ($signed(CW'(c)) < rect_hi);
            end
            else
            begin
                fill_mask[c] = ($signed(CW'(c)) >= disc_lo) && ($signed(CW'(c)) <= disc_hi);
            end
        end
    end

    assign row_pad = PADW'(rd_data);

    // Datapath next values
    always_comb
    begin
        yy_next         = yy_reg;
        yend_next       = yend_reg;
        cmd_next        = cmd_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        w_next          = w_reg;
        r_next          = r_reg;
        seg_next        = seg_reg;
        row_buf_next    = row_buf_reg;
        frame_hash_next = frame_hash_reg;
        row_pixels_next = row_pixels_reg;
        wr_pending_next = (state_reg == ST_RECT) || (state_reg == ST_DISC_RD);
        wr_row_next     = yy_reg[ROW_AW-1:0];

        // Take the command and set up its row range
        if (accept)
        begin
            cmd_next     = in_cmd;
            px_next      = in_px;
            py_next      = in_py;
            w_next       = s_tdata[27:20];
            r_next       = s_tdata[43:36];
            seg_next     = s_tdata[44];
            row_buf_next = '0;
            unique case (in_cmd)
                CMD_RECT:
                begin
                    yy_next   = rect_y0;
                    yend_next = rect_yend;
                end
                CMD_DISC:
                begin
                    yy_next   = disc_y0;
                    yend_next = disc_y1 + ONE_S;
                end
                CMD_HASH:
                begin
                    yy_next   = '0;
                    yend_next = H_S;
                end
                CMD_READ:
                begin
                    yy_next   = in_py;
                    yend_next = in_py + ONE_S;
                end
                default:
                begin
                    yy_next   = '0;
                    yend_next = '0;
                end
            endcase
        end

        // Advance the row
        if ((state_reg == ST_CLEAR) || (state_reg == ST_RECT) || (state_reg == ST_DISC_WR) ||
            ((state_reg == ST_HASH_RUN) && !hash_busy))
        begin
            yy_next = yy_reg + ONE_S;
        end

        // Capture the requested segment
        if (state_reg == ST_RD_WAIT)
        begin
            row_buf_next = seg_reg ? row_pad[127:64] : row_pad[63:0];
        end

        // Load the result register
        if (out_load)
        begin
            frame_hash_next = (cmd_reg == CMD_HASH) ? hash_val : '0;
            row_pixels_next = row_buf_reg;
        end

        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            yy_reg         <= '0;
            yend_reg       <= '0;
            wr_pending_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            yy_reg         <= yy_next;
            yend_reg       <= yend_next;
            wr_pending_reg <= wr_pending_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row_reg     <= wr_row_next;
        cmd_reg        <= cmd_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        w_reg          <= w_next;
        r_reg          <= r_next;
        seg_reg        <= seg_next;
        row_buf_reg    <= row_buf_next;
        frame_hash_reg <= frame_hash_next;
        row_pixels_reg <= row_pixels_next;
    end

    cfe_frame_mem #(
        .DEPTH (FRAME_HEIGHT),
        .WIDTH (FRAME_WIDTH),
        .AW    (ROW_AW)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfe_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (span_sq),
        .done     (sqrt_done),
        .root     (root)
    );

    cfe_fnv_hash #(
        .WIDTH (FRAME_WIDTH)
    ) u_fnv_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (hash_ctrl),
        .row_data (rd_data),
        .busy     (hash_busy),
        .hash     (hash_val)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, 1'b1, row_pixels_reg, frame_hash_reg};

    // Checks on sequencing
    `CFE_ASSERT_IMP(a_no_row_collide, wr_en && rd_en, wr_addr != rd_addr, "frame store read and write on the same row")
    `CFE_ASSERT_IMP(a_sqrt_done_in_wait, sqrt_done, state_reg == ST_DISC_SQRT, "square root finished outside its wait state")
    `CFE_ASSERT_IMP(a_hash_busy_in_run, hash_busy, state_reg == ST_HASH_RUN, "hasher busy outside the hash run state")
    `CFE_ASSERT_NEXT(a_result_loaded, out_load, m_tvalid_reg, "result register not valid after load")

endmodule

@@ tb/sv/clipped_shape_fill_engine_top_tb.sv @@
// Self-checking testbench for clipped_shape_fill_engine_top: shape fills, frame hash and row reads.
// Keeps a shadow framebuffer that predicts each result; depends only on cfe_pkg and the RTL.
module clipped_shape_fill_engine_top_tb;

    import cfe_pkg::*;

    localparam int          FRAME_W     = 128;
    localparam int          FRAME_H     = 128;
    localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;
    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [63:0] frame_hash;
        logic [63:0] row_pixels;
        logic        done_res;
    } result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = 2'b00;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the frame: bit x of row y is pixel (x, y)
    logic [FRAME_W-1:0] shadow_frame [FRAME_H];
    result_t            results_due [$];
    int                 error_count = 0;
    int                 burst_left  = 0;
    int                 rx_ticks    = 0;
    int                 cycle_count = 0;

    clipped_shape_fill_engine_top #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Set one pixel, dropping anything off the frame
    function automatic void shadow_set(input int x, input int y);
        if (x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H)
            shadow_frame[y][x] = 1'b1;
    endfunction

    function automatic void shadow_fill_rect(input int x, input int y, input int w, input int h);
        int x0, x1, y0, y1;
        x0 = (x < 0) ? 0 : x;
        x1 = (x + w > FRAME_W) ? FRAME_W : x + w;
        y0 = (y < 0) ? 0 : y;
        y1 = (y + h > FRAME_H) ? FRAME_H : y + h;
        for (int yy = y0; yy < y1; yy++)
            for (int xx = x0; xx < x1; xx++)
                shadow_set(xx, yy);
    endfunction

    function automatic void shadow_fill_disc(input int cx, input int cy, input int r);
        int x0, x1, y0, y1, rr;
        rr = r * r;
        y0 = (cy - r < 0) ? 0 : cy - r;
        y1 = (cy + r >= FRAME_H) ? FRAME_H - 1 : cy + r;
        x0 = (cx - r < 0) ? 0 : cx - r;
        x1 = (cx + r >= FRAME_W) ? FRAME_W - 1 : cx + r;
        for (int yy = y0; yy <= y1; yy++)
            for (int xx = x0; xx <= x1; xx++)
                if ((xx - cx) * (xx - cx) + (yy - cy) * (yy - cy) <= rr)
                    shadow_set(xx, yy);
    endfunction

    // FNV-1a 64 over every pixel in row-major order, one byte of 0 or 1 each
    function automatic logic [63:0] shadow_hash();
        logic [63:0] h;
        h = FNV_BASIS;
        for (int y = 0; y < FRAME_H; y++)
            for (int x = 0; x < FRAME_W; x++)
                h = (h ^ {63'd0, shadow_frame[y][x]}) * FNV_PRIME;
        return h;
    endfunction

    // Apply one command to the shadow frame and return the result it should give
    function automatic result_t execute_on_shadow(input cmd_t kind, input logic [9:0] xf,
                                                  input logic [9:0] yf, input logic [7:0] w,
                                                  input logic [7:0] h, input logic [7:0] r,
                                                  input logic seg);
        result_t res;
        int      px, py;
        px = int'($signed(xf));
        py = int'($signed(yf));
        res = '0;
        res.done_res = 1'b1;
        case (kind)
            CMD_RECT: shadow_fill_rect(px, py, int'(w), int'(h));
            CMD_DISC: shadow_fill_disc(px, py, int'(r));
            CMD_HASH: res.frame_hash = shadow_hash();
            default:
            begin
                if (py >= 0 && py < FRAME_H)
                    res.row_pixels = seg ? shadow_frame[py][127:64] : shadow_frame[py][63:0];
            end
        endcase
        return res;
    endfunction

    // Send one command item in bursts with random gaps, then record its expected result
    task automatic issue_command(input cmd_t kind, input int x, input int y, input int w,
                                 input int h, input int r, input int seg);
        int         gap;
        logic [9:0] xf, yf;
        xf = x[9:0];
        yf = y[9:0];
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, seg[0], r[7:0], h[7:0], w[7:0], yf, xf};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        results_due.push_back(execute_on_shadow(kind, xf, yf, w[7:0], h[7:0], r[7:0], seg[0]));
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (results_due.size() != 0);
    endtask

    function automatic int rand_byte();
        return $urandom_range(0, 255);
    endfunction

    function automatic int rand_pos();
        return $urandom_range(0, 1023) - 512;
    endfunction

    // Blank frame: hash of all zeros and reads of empty rows
    task automatic test_empty_frame();
        issue_command(CMD_HASH, rand_pos(), rand_pos(), rand_byte(), rand_byte(), rand_byte(), 0);
        issue_command(CMD_READ, rand_pos(), 0, rand_byte(), rand_byte(), rand_byte(), 0);
        issue_command(CMD_READ, rand_pos(), 127, rand_byte(), rand_byte(), rand_byte(), 1);
    endtask

    // Zero sizes, shapes partly and wholly off the frame, reads outside the frame
    task automatic test_clipping_cases();
        issue_command(CMD_RECT, 10, 10, 0, 5, rand_byte(), 1);
        issue_command(CMD_RECT, 10, 10, 5, 0, rand_byte(), 0);
        issue_command(CMD_RECT, -512, -512, 255, 255, rand_byte(), 1);
        issue_command(CMD_RECT, 511, 511, 255, 255, rand_byte(), 0);
        issue_command(CMD_RECT, -3, -2, 6, 4, rand_byte(), 1);
        issue_command(CMD_RECT, 120, 126, 255, 255, 0, 0);
        issue_command(CMD_READ, rand_pos(), 0, rand_byte(), rand_byte(), rand_byte(), 0);
        issue_command(CMD_READ, rand_pos(), 127, rand_byte(), rand_byte(), rand_byte(), 1);
        issue_command(CMD_DISC, 64, 64, rand_byte(), rand_byte(), 0, 1);
        issue_command(CMD_READ, rand_pos(), 64, rand_byte(), rand_byte(), rand_byte(), 1);
        issue_command(CMD_DISC, -2, 40, rand_byte(), rand_byte(), 5, 0);
        issue_command(CMD_DISC, 130, 100, rand_byte(), rand_byte(), 4, 1);
        issue_command(CMD_DISC, -512, 100, rand_byte(), rand_byte(), 255, 0);
        issue_command(CMD_READ, rand_pos(), 40, rand_byte(), rand_byte(), rand_byte(), 0);
        issue_command(CMD_READ, rand_pos(), 100, rand_byte(), rand_byte(), rand_byte(), 1);
        issue_command(CMD_READ, rand_pos(), -1, rand_byte(), rand_byte(), rand_byte(), 0);
        issue_command(CMD_READ, rand_pos(), 128, rand_byte(), rand_byte(), rand_byte(), 1);
        issue_command(CMD_READ, rand_pos(), 511, rand_byte(), rand_byte(), rand_byte(), 0);
        issue_command(CMD_READ, rand_pos(), -512, rand_byte(), rand_byte(), rand_byte(), 1);
        issue_command(CMD_HASH, rand_pos(), rand_pos(), rand_byte(), rand_byte(), rand_byte(), 1);
    endtask

    // Mostly small shapes near the frame so that the picture stays varied;
    // unused fields carry random values throughout
    task automatic test_random_small_shapes(input int count);
        int pick, x, y, w, h, r;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_for_drain();
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
            begin
                x = rand_pos();
                y = rand_pos();
            end
            else
            begin
                x = $urandom_range(0, 167) - 20;
                y = $urandom_range(0, 167) - 20;
            end
            if (pick < 30)
            begin
                // Occasional thin stripe with one long side
                if ($urandom_range(0, 9) == 0)
                begin
                    w = rand_byte();
                    h = $urandom_range(0, 3);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        h = w;
                        w = $urandom_range(0, 3);
                    end
                end
                else
                begin
                    w = $urandom_range(0, 12);
                    h = $urandom_range(0, 12);
                end
                issue_command(CMD_RECT, x, y, w, h, rand_byte(), $urandom_range(0, 1));
            end
            else if (pick < 55)
            begin
                r = $urandom_range(0, 6);
                issue_command(CMD_DISC, x, y, rand_byte(), rand_byte(), r, $urandom_range(0, 1));
            end
            else if (pick < 97)
            begin
                if ($urandom_range(0, 7) != 0)
                    y = $urandom_range(0, FRAME_H - 1);
                issue_command(CMD_READ, x, y, rand_byte(), rand_byte(), rand_byte(),
                              $urandom_range(0, 1));
            end
            else
                issue_command(CMD_HASH, x, y, rand_byte(), rand_byte(), rand_byte(),
                              $urandom_range(0, 1));
        end
    endtask

    // Every field across its whole range, finishing with a hash of the result
    task automatic test_random_full_range(input int count);
        int   pick;
        cmd_t kind;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                kind = CMD_RECT;
            else if (pick < 60)
                kind = CMD_DISC;
            else if (pick < 90)
                kind = CMD_READ;
            else
                kind = CMD_HASH;
            issue_command(kind, rand_pos(), rand_pos(), rand_byte(), rand_byte(), rand_byte(),
                          $urandom_range(0, 1));
        end
        issue_command(CMD_HASH, rand_pos(), rand_pos(), rand_byte(), rand_byte(), rand_byte(),
                      $urandom_range(0, 1));
    endtask

    // Check each result item against the oldest expectation, then pick the next stall
    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        int      mode;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.frame_hash = m_tdata[63:0];
            got.row_pixels = m_tdata[127:64];
            got.done_res   = m_tdata[128];
            if (results_due.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result item: hash %h pixels %h done %b",
                             got.frame_hash, got.row_pixels, got.done_res);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.frame_hash !== want.frame_hash || got.row_pixels !== want.row_pixels
                    || got.done_res !== want.done_res)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected hash %h pixels %h done %b, got hash %h pixels %h done %b",
                                 want.frame_hash, want.row_pixels, want.done_res,
                                 got.frame_hash, got.row_pixels, got.done_res);
                end
            end
        end
        // Cycle through always ready, coin-toss, sparse and periodic stalls
        rx_ticks++;
        mode = (rx_ticks / 97) % 4;
        case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= (rx_ticks % 6 < 2);
        endcase
    end

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("clipped_shape_fill_engine_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        for (int y = 0; y < FRAME_H; y++)
            shadow_frame[y] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_frame();
        test_clipping_cases();
        test_random_small_shapes(380);
        test_random_full_range(50);

        // Drain, then allow for any stray result
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && results_due.size() == 0)
            $display("clipped_shape_fill_engine_top regression: pass");
        else
            $display("clipped_shape_fill_engine_top regression: fail");
        $finish;
    end

endmodule
